/* src/mhash_pkg.sv */
// Shared types and constants of the MurmurHash64A block.
package mhash_pkg;

  // Hash multiplier and shift of the mixing steps.
  localparam logic [63:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT  = 47;
  localparam logic [63:0] SEED_RESET = 64'h0000_0000_1234_abcd;

  // Depth of the queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Kind of a word after byte-count classification.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TAIL,
    KIND_FULL
  } mhash_kind_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_DISP,
    ST_K1,
    ST_K2,
    ST_HMUL,
    ST_FIN
  } mhash_state_t;

  // One classified word as it sits in the queue.
  typedef struct packed {
    logic [63:0] word;
    mhash_kind_t kind;
    logic        first;
    logic        last;
    logic [31:0] length;
  } mhash_item_t;

  // Status of the back end seen by the top level.
  typedef struct packed {
    logic pop;
    logic emit;
  } mhash_stat_t;

endpackage

/* src/mhash_front.sv */
// Front end: accepts input words, masks and classifies them, tracks key boundaries.
module mhash_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [63:0]           in_key_word,
  input  logic [3:0]            in_word_bytes,
  input  logic                  in_last_word,
  input  logic [31:0]           in_key_length,
  input  logic                  q_full,
  output logic                  q_push,
  output mhash_pkg::mhash_item_t q_item
);
  import mhash_pkg::*;

  logic        inside_r;
  logic        inside_nxt;
  logic [3:0]  nbytes;
  logic [63:0] masked;

  // A word is taken whenever the queue has room.
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Byte counts above eight count as eight.
  assign nbytes = in_word_bytes[3] ? 4'd8 : in_word_bytes;

  // Clear the bytes beyond the count.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[i*8 +: 8] = (4'(i) < nbytes) ? in_key_word[i*8 +: 8] : 8'h00;
    end
  end

  // Build the queue word.
  always_comb begin
    q_item.word   = masked;
    q_item.first  = !inside_r;
    q_item.last   = in_last_word;
    q_item.length = in_key_length;
    if (nbytes == 4'd8) begin
      q_item.kind = KIND_FULL;
    end else if (nbytes == 4'd0) begin
      q_item.kind = KIND_NONE;
    end else begin
      q_item.kind = KIND_TAIL;
    end
  end

  // A key is open from its first word until its last word.
  assign inside_nxt = q_push ? !in_last_word : inside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
    end else begin
      inside_r <= inside_nxt;
    end
  end

endmodule

/* src/mhash_queue.sv */
// Short queue of classified words between the front end and the back end.
module mhash_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mhash_pkg::mhash_item_t push_item,
  input  logic                  pop,
  output mhash_pkg::mhash_item_t head_item,
  output logic                  head_valid,
  output logic                  full
);
  import mhash_pkg::*;

  mhash_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, wp_nxt;
  logic [QPTR_W-1:0]   rp_r, rp_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rp_r];

  // Pointer and count updates.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

/* src/mhash_core.sv */
// Back end: sequences the mixing steps over one shared 32x32 multiplier and holds the result.
module mhash_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [63:0]           seed,
  input  mhash_pkg::mhash_item_t head_item,
  input  logic                  head_valid,
  output logic                  pop,
  output mhash_pkg::mhash_stat_t stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [63:0]           out_hash_value
);
  import mhash_pkg::*;

  mhash_state_t state_r, state_nxt;
  logic [1:0]   step_r, step_nxt;
  logic [63:0]  a_r, a_nxt;
  logic [63:0]  p_r, p_nxt;
  logic [31:0]  c_r, c_nxt;
  logic [63:0]  h_r, h_nxt;
  mhash_item_t  item_r, item_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [63:0]  out_hash_r, out_hash_nxt;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod;
  logic [63:0]  mres;
  logic         mul_done;
  logic         slot_free;
  logic         emit;
  logic [63:0]  kmix, hfold, hfin, hdisp;

  // One 32x32 multiplier; a product by the constant takes three steps:
  // low x low, high x low, low x high (the last two only to 32 bits).
  always_comb begin
    case (step_r)
      2'd0:    begin mul_a = a_r[31:0];  mul_b = MIX_MUL[31:0];  end
      2'd1:    begin mul_a = a_r[63:32]; mul_b = MIX_MUL[31:0];  end
      default: begin mul_a = a_r[31:0];  mul_b = MIX_MUL[63:32]; end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign mres     = p_r + {c_r + prod[31:0], 32'h0};
  assign mul_done = (step_r == 2'd2);

  // Helper values of the mixing recurrence.
  assign kmix  = mres ^ (mres >> MIX_SHIFT);
  assign hfold = h_r ^ mres;
  assign hfin  = mres ^ (mres >> MIX_SHIFT);
  assign hdisp = h_r ^ item_r.word;

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = (state_r == ST_FIN) && mul_done && slot_free;
  assign pop       = (state_r == ST_IDLE) && head_valid;
  assign stat.pop  = pop;
  assign stat.emit = emit;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (head_valid) begin
          state_nxt = head_item.first ? ST_SEED : ST_DISP;
        end
      end
      ST_SEED: begin
        if (mul_done) state_nxt = ST_DISP;
      end
      ST_DISP: begin
        case (item_r.kind)
          KIND_FULL: state_nxt = ST_K1;
          KIND_TAIL: state_nxt = ST_HMUL;
          default:   state_nxt = item_r.last ? ST_FIN : ST_IDLE;
        endcase
      end
      ST_K1: begin
        if (mul_done) state_nxt = ST_K2;
      end
      ST_K2: begin
        if (mul_done) state_nxt = ST_HMUL;
      end
      ST_HMUL: begin
        if (mul_done) state_nxt = item_r.last ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (emit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates for each state.
  always_comb begin
    step_nxt      = step_r;
    a_nxt         = a_r;
    p_nxt         = p_r;
    c_nxt         = c_r;
    h_nxt         = h_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_hash_nxt  = out_hash_r;

    // Partial products of the running multiplication.
    if (state_r != ST_IDLE && state_r != ST_DISP) begin
      case (step_r)
        2'd0:    begin p_nxt = prod;        step_nxt = 2'd1; end
        2'd1:    begin c_nxt = prod[31:0];  step_nxt = 2'd2; end
        default: step_nxt = 2'd2;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        step_nxt = 2'd0;
        if (head_valid) begin
          item_nxt = head_item;
          a_nxt    = {32'h0, head_item.length};
        end
      end
      ST_SEED: begin
        if (mul_done) begin
          h_nxt = seed ^ mres;
        end
      end
      ST_DISP: begin
        step_nxt = 2'd0;
        case (item_r.kind)
          KIND_FULL: a_nxt = item_r.word;
          KIND_TAIL: a_nxt = hdisp;
          default:   a_nxt = h_r ^ (h_r >> MIX_SHIFT);
        endcase
      end
      ST_K1: begin
        if (mul_done) begin
          a_nxt    = kmix;
          step_nxt = 2'd0;
        end
      end
      ST_K2: begin
        if (mul_done) begin
          a_nxt    = hfold;
          step_nxt = 2'd0;
        end
      end
      ST_HMUL: begin
        if (mul_done) begin
          h_nxt    = mres;
          a_nxt    = mres ^ (mres >> MIX_SHIFT);
          step_nxt = 2'd0;
        end
      end
      ST_FIN: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = hfin;
          h_nxt         = '0;
          step_nxt      = 2'd0;
        end
      end
      default: step_nxt = 2'd0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
      h_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      h_r         <= h_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    p_r        <= p_nxt;
    c_r        <= c_nxt;
    item_r     <= item_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

/* src/murmur64a_hash.sv */
// MurmurHash64A engine: seed register, front end, word queue and mixing back end.
// Each 64-bit product is built on the back end's one 32x32 multiplier.
// The last word of a key may also wait for the output register to be free.
// Synchronous active-low reset clears queue, sequencer and output valid; seed is 0x1234ABCD.
module murmur64a_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_hash_seed,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_key_word,
  input  logic [3:0]  in_word_bytes,
  input  logic        in_last_word,
  input  logic [31:0] in_key_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash_value
);
  import mhash_pkg::*;

  logic [63:0] seed_r, seed_nxt;
  logic        q_push, q_full, q_pop, q_valid;
  mhash_item_t q_in, q_head;
  mhash_stat_t stat;

  // Seed register, always writable.
  assign cfg_ready = 1'b1;
  assign seed_nxt  = (cfg_valid && cfg_ready) ? cfg_hash_seed : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  mhash_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_key_word   (in_key_word),
    .in_word_bytes (in_word_bytes),
    .in_last_word  (in_last_word),
    .in_key_length (in_key_length),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  mhash_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in),
    .pop        (q_pop),
    .head_item  (q_head),
    .head_valid (q_valid),
    .full       (q_full)
  );

  mhash_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .seed           (seed_r),
    .head_item      (q_head),
    .head_valid     (q_valid),
    .pop            (q_pop),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

  // A word is only taken from the queue when one is there.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pop |-> q_valid)
    else $error("queue popped while empty");

  // A finished hash is shown on the next cycle.
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit |=> out_valid)
    else $error("finished hash not presented");

  // A new result appears only after the sequencer finished a key.
  a_valid_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(stat.emit))
    else $error("result valid without a finished key");

endmodule

/* test/testbench.sv */
// Self-checking testbench of the MurmurHash64A block, with a word driver and a hash checker.
module testbench;
  import mhash_pkg::*;

  // One input word as it waits in the driver queue.
  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
    logic [31:0] length;
  } key_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_hash_seed = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_key_word = '0;
  logic [3:0]  in_word_bytes = '0;
  logic        in_last_word = 1'b0;
  logic [31:0] in_key_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_hash_value;

  key_word_t   pending_words[$];
  logic [63:0] expected_hashes[$];
  int unsigned words_sent = 0;
  int unsigned words_accepted = 0;
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Predicted block state: seed register, running hash and key flag.
  logic [63:0] seed_reg = SEED_RESET;
  logic [63:0] run_hash = '0;
  logic        in_key = 1'b0;

  murmur64a_hash u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_hash_seed  (cfg_hash_seed),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_key_word    (in_key_word),
    .in_word_bytes  (in_word_bytes),
    .in_last_word   (in_last_word),
    .in_key_length  (in_key_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

  always #10 clk = ~clk;

  // Folds one word of nbytes bytes into the running hash; counts above eight act as eight.
  function automatic logic [63:0] absorb_word(logic [63:0] h, logic [63:0] w,
                                              logic [3:0] nbytes);
    logic [63:0] k;
    int unsigned n;
    n = (nbytes > 4'd8) ? 8 : nbytes;
    if (n == 8) begin
      k = w * MIX_MUL;
      k = k ^ (k >> MIX_SHIFT);
      k = k * MIX_MUL;
      h = (h ^ k) * MIX_MUL;
    end else if (n != 0) begin
      h = (h ^ (w & ((64'd1 << (8 * n)) - 64'd1))) * MIX_MUL;
    end
    return h;
  endfunction

  // Final avalanche applied on the last word of a key.
  function automatic logic [63:0] finalize_hash(logic [63:0] h);
    h = h ^ (h >> MIX_SHIFT);
    h = h * MIX_MUL;
    return h ^ (h >> MIX_SHIFT);
  endfunction

  function automatic void push_word(logic [63:0] w, logic [3:0] nbytes, logic last,
                                    logic [31:0] length);
    key_word_t item;
    item.word   = w;
    item.nbytes = nbytes;
    item.last   = last;
    item.length = length;
    pending_words.push_back(item);
  endfunction

  // Queues one key and returns its number of words. Most keys are well formed with
  // random content; the rest are random byte counts, including counts above eight.
  function automatic int unsigned queue_key();
    int unsigned len, nfull, tail, nwords;
    logic [31:0] len_field;
    if ($urandom_range(99) < 80) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(40);
      len_field = ($urandom_range(9) == 0) ? $urandom : len;
      nfull = len / 8;
      tail = len % 8;
      if (len == 0) begin
        push_word({$urandom, $urandom}, 4'd0, 1'b1, len_field);
        return 1;
      end
      for (int unsigned i = 0; i < nfull; i++) begin
        push_word({$urandom, $urandom}, 4'd8, (tail == 0) && (i == nfull - 1),
                  (i == 0) ? len_field : $urandom);
      end
      if (tail != 0) begin
        push_word({$urandom, $urandom}, tail[3:0], 1'b1, (nfull == 0) ? len_field : $urandom);
      end
      return nfull + ((tail != 0) ? 1 : 0);
    end
    nwords = $urandom_range(1, 4);
    for (int unsigned i = 0; i < nwords; i++) begin
      push_word({$urandom, $urandom}, 4'($urandom_range(15)), i == nwords - 1, $urandom);
    end
    return nwords;
  endfunction

  // Writes the seed register through its own channel; only called while the block is idle.
  task automatic write_seed(input logic [63:0] value);
    @(negedge clk);
    cfg_valid     <= 1'b1;
    cfg_hash_seed <= value;
    do @(posedge clk); while (!cfg_ready);
    seed_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued word is taken and every hash has come back.
  task automatic drain();
    while (pending_words.size() != 0 || words_sent != words_accepted ||
           expected_hashes.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Driver: offers the next word at the falling edge once the current one is taken.
  always @(negedge clk) begin : word_driver
    key_word_t item;
    if (rst_n && !(in_valid && words_sent != words_accepted)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item = pending_words.pop_front();
        in_valid      <= 1'b1;
        in_key_word   <= item.word;
        in_word_bytes <= item.nbytes;
        in_last_word  <= item.last;
        in_key_length <= item.length;
        words_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls at random.
  always @(negedge clk) begin : hash_sink
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Predictor: each accepted word updates the model state; a last word yields a hash.
  always @(posedge clk) begin : hash_predictor
    logic [63:0] h;
    if (rst_n && in_valid && in_ready) begin
      words_accepted++;
      h = in_key ? run_hash : (seed_reg ^ ({32'd0, in_key_length} * MIX_MUL));
      h = absorb_word(h, in_key_word, in_word_bytes);
      if (in_last_word) begin
        expected_hashes.push_back(finalize_hash(h));
        run_hash = '0;
        in_key = 1'b0;
      end else begin
        run_hash = h;
        in_key = 1'b1;
      end
    end
  end

  // Checker: every accepted hash is compared with the oldest prediction.
  always @(posedge clk) begin : hash_checker
    logic [63:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_hashes.size() == 0) begin
        $error("hash_value: expected nothing, actual %h", out_hash_value);
        error_count++;
      end else begin
        want = expected_hashes.pop_front();
        if (out_hash_value !== want) begin
          $error("hash_value: expected %h, actual %h", want, out_hash_value);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [63:0] seed_list [6];
    int unsigned queued;
    seed_list[0] = '1;
    seed_list[1] = '0;
    seed_list[2] = {$urandom, $urandom};
    seed_list[3] = 64'h8000_0000_0000_0000;
    seed_list[4] = {$urandom, $urandom};
    seed_list[5] = {$urandom, $urandom};
    send_idle_pct = 30;
    recv_idle_pct = 80;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed keys under the reset seed: empty keys, extreme words, every tail size,
    // oversized counts, short and empty words inside a key, a mismatched length.
    push_word({$urandom, $urandom}, 4'd0, 1'b1, 32'd0);
    push_word({$urandom, $urandom}, 4'd0, 1'b1, 32'hffff_ffff);
    push_word('1, 4'd8, 1'b1, 32'd8);
    push_word('0, 4'd8, 1'b1, 32'd8);
    for (int unsigned n = 1; n < 8; n++) begin
      push_word({$urandom, $urandom}, n[3:0], 1'b1, n);
    end
    push_word({$urandom, $urandom}, 4'd15, 1'b1, 32'd8);
    push_word({$urandom, $urandom}, 4'd9, 1'b1, 32'd8);
    push_word({$urandom, $urandom}, 4'd8, 1'b0, 32'd11);
    push_word('1, 4'd3, 1'b1, 32'd0);
    push_word('1, 4'd3, 1'b0, 32'd11);
    push_word({$urandom, $urandom}, 4'd8, 1'b1, 32'hffff_ffff);
    push_word({$urandom, $urandom}, 4'd0, 1'b0, 32'd5);
    push_word({$urandom, $urandom}, 4'd5, 1'b1, 32'd0);
    push_word({$urandom, $urandom}, 4'd8, 1'b0, 32'd24);
    push_word({$urandom, $urandom}, 4'd8, 1'b0, 32'd0);
    push_word({$urandom, $urandom}, 4'd8, 1'b1, 32'd0);
    drain();

    // Random keys over several seeds and idle patterns.
    for (int unsigned phase = 0; phase < 6; phase++) begin
      send_idle_pct = (phase < 2) ? 30 : (phase < 4) ? 80 : 0;
      recv_idle_pct = (phase < 2) ? 80 : (phase < 4) ? 30 : 0;
      write_seed(seed_list[phase]);
      queued = 0;
      while (queued < 105) queued += queue_key();
      drain();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
